>>> hw/rtl/fixed_block_free_list_allocator_macros.svh
// ============================================================================
// Assertion macros for the block pool allocator
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ============================================================================
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH

// invariant that holds at every clock edge
`define FBFL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// same-cycle implication
`define FBFL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fbfl_pkg.sv
// ============================================================================
// fbfl_pkg
// Shared types and constants of the block pool allocator.
// ============================================================================
package fbfl_pkg;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int IDX_W    = 8;
  localparam int STAT_W   = 2;
  localparam int OFS_W    = 24;
  localparam int CNT_W    = 9;
  localparam int SIZE_W   = 16;
  localparam int CFG_A_W  = 1;
  localparam int CFG_D_W  = 16;
  localparam int IN_TD_W  = 16;
  localparam int OUT_TD_W = 40;
  localparam int MIN_SIZE = 4;

  // reset values of the registers
  localparam logic [CNT_W-1:0]  COUNT_RST = 9'd256;
  localparam logic [SIZE_W-1:0] BYTES_RST = 16'd4;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_BLOCK_COUNT = 1'b0,
    CFG_BLOCK_BYTES = 1'b1
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic init_step;  // write one link of the init chain
    logic exec;       // finish the item and load the output
  } fbfl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_init; // op on the input bus is an init
    logic count_zero; // effective block count is zero
    logic init_last;  // current init step writes the tail link
    logic out_free;   // output register can take a result
  } fbfl_sts_t;

endpackage

>>> hw/rtl/fixed_block_free_list_allocator.sv
// ============================================================================
// fixed_block_free_list_allocator
// Pool allocator of equal-sized blocks kept on an intrusive free list.
// ============================================================================
// Usage:
//   Input stream carries one request: init the free list, allocate a block
//   or free a block. Every request yields exactly one result transaction on
//   the output stream: status, granted block index and its byte offset
//   (index times block size, sizes below 4 taken as 4).
//   Config port writes block_count (index 0) and block_bytes (index 1);
//   write only while the block is idle.
//   Sequence: allocate, free and no-op pass from accept to the execute
//   state, which loads the output register once it is free; init first
//   walks the init state, one link memory write per block (none for a zero
//   count), then executes. A new request is taken only after the current
//   one has executed; a pop needs the registered read of the link memory, started at accept, before the head can move.
//   Reset: list empty (allocate reports pool empty until an init), count
//   256, block size 4. The link memory is not cleared.
//   Stall: one result waits in the output register; one more request is
//   accepted and held until that result is taken.
// ============================================================================
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  // config write port
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [CFG_D_W-1:0]  cfg_wdata,
  // request stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_TD_W-1:0]  in_tdata,   // op[1:0], block_index[9:2], zero pad
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TD_W-1:0] out_tdata   // status[1:0], granted_index[9:2],
                                          // byte_offset[33:10], zero pad
);

  fbfl_cmd_t cmd;
  fbfl_sts_t sts;

  fbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbfl_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

>>> hw/rtl/fbfl_ram.sv
// ============================================================================
// fbfl_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module fbfl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/fbfl_ctrl.sv
// ============================================================================
// fbfl_ctrl
// Sequencer of the allocator: accept, init walk, execute and hand off.
// ============================================================================
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  fbfl_sts_t sts,
  output fbfl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  // commands
  always_comb begin
    cmd.accept    = (state_r == S_IDLE) && in_tvalid;
    cmd.init_step = (state_r == S_INIT) && !sts.count_zero;
    cmd.exec      = (state_r == S_EXEC) && sts.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = sts.in_is_init ? S_INIT : S_EXEC;
        end
      end
      S_INIT: begin
        if (sts.count_zero || sts.init_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

>>> hw/rtl/fbfl_dp.sv
// ============================================================================
// fbfl_dp
// Datapath: config registers, free-list head, link memory, offset multiply
// and the output register.
// ============================================================================
`include "fixed_block_free_list_allocator_macros.svh"

module fbfl_dp
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  // config
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [CFG_D_W-1:0]  cfg_wdata,
  // input payload
  input  logic [IN_TD_W-1:0]  in_tdata,
  // output channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TD_W-1:0] out_tdata,
  // controller
  input  fbfl_cmd_t           cmd,
  output fbfl_sts_t           sts
);

  localparam int IW = $clog2(MAX_BLOCKS);          // block index bits
  localparam int LW = IW + 1;                      // link bits, holds marker
  localparam int CW = (LW > CNT_W) ? LW : CNT_W;   // compare width
  localparam logic [LW-1:0] EMPTY = LW'(MAX_BLOCKS);

  // registers
  logic [CNT_W-1:0]  block_count_r;
  logic [SIZE_W-1:0] block_bytes_r;
  logic [LW-1:0]     head_r, head_nxt;
  logic [LW-1:0]     cnt_r;
  op_t               op_r;
  logic [IDX_W-1:0]  idx_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [OFS_W-1:0]  out_offset_r;

  // combinational
  logic [LW-1:0]     count_eff;
  logic [SIZE_W-1:0] eff_size;
  logic              head_empty;
  logic              idx_oor;
  logic              free_push;
  logic [LW-1:0]     cnt_inc;
  logic [LW-1:0]     rd_link;
  logic [LW-1:0]     next_head;
  logic [IW+SIZE_W-1:0] prod;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [LW-1:0]     ram_wdata;
  status_t           res_status;
  logic [IDX_W-1:0]  res_index;
  logic [OFS_W-1:0]  res_offset;
  logic              out_free;

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= COUNT_RST;
      block_bytes_r <= BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_BLOCK_COUNT: block_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_BLOCK_BYTES: block_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective count and size
  assign count_eff = (CW'(block_count_r) > CW'(MAX_BLOCKS)) ? EMPTY : LW'(block_count_r);
  assign eff_size  = (block_bytes_r < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) : block_bytes_r;

  assign head_empty = (head_r >= EMPTY);
  assign idx_oor    = (CW'(idx_r) >= CW'(count_eff));
  assign free_push  = cmd.exec && (op_r == OP_FREE) && !idx_oor;
  assign cnt_inc    = cnt_r + LW'(1);

  // link memory
  fbfl_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (head_r[IW-1:0]),
    .rdata (rd_link)
  );

  // write port: init chain or push on free
  always_comb begin
    if (cmd.init_step) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r[IW-1:0];
      ram_wdata = sts.init_last ? EMPTY : cnt_inc;
    end else begin
      ram_we    = free_push;
      ram_waddr = IW'(idx_r);
      ram_wdata = head_r;
    end
  end

  assign next_head = (rd_link >= EMPTY) ? EMPTY : rd_link;
  assign prod      = head_r[IW-1:0] * eff_size;

  // result and head update of the current item
  always_comb begin
    head_nxt   = head_r;
    res_status = ST_OK;
    res_index  = '0;
    res_offset = '0;
    case (op_r)
      OP_INIT: begin
        head_nxt = (count_eff == '0) ? EMPTY : '0;
      end
      OP_ALLOC: begin
        if (head_empty) begin
          res_status = ST_EMPTY;
        end else begin
          head_nxt   = next_head;
          res_index  = IDX_W'(head_r);
          res_offset = OFS_W'(prod);
        end
      end
      OP_FREE: begin
        if (idx_oor) begin
          res_status = ST_RANGE;
        end else begin
          head_nxt = LW'(idx_r);
        end
      end
      default: ;
    endcase
  end

  // head, latched item and init counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= EMPTY;
      cnt_r  <= '0;
    end else begin
      if (cmd.exec) begin
        head_r <= head_nxt;
      end
      if (cmd.accept) begin
        cnt_r <= '0;
      end else if (cmd.init_step) begin
        cnt_r <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= op_t'(in_tdata[OP_W-1:0]);
      idx_r <= in_tdata[OP_W+IDX_W-1:OP_W];
    end
  end

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_offset_r <= res_offset;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TD_W-STAT_W-IDX_W-OFS_W)'(0), out_offset_r, out_index_r,
                       out_status_r};

  // status to the controller
  always_comb begin
    sts.in_is_init = (op_t'(in_tdata[OP_W-1:0]) == OP_INIT);
    sts.count_zero = (count_eff == '0);
    sts.init_last  = (cnt_inc == count_eff);
    sts.out_free   = out_free;
  end

  // checks
  `FBFL_ASSERT_ALWAYS(a_head_bound, head_r <= EMPTY, "free head beyond empty marker")
  `FBFL_ASSERT_IMPL(a_init_bound, cmd.init_step, cnt_r < count_eff, "init walk past count")
  `FBFL_ASSERT_NEXT(a_exec_out, cmd.exec, out_valid_r, "finished item left no result")
  `FBFL_ASSERT_NEXT(a_free_push, free_push, head_r == $past(LW'(idx_r)), "freed block not at head")

endmodule

>>> test/fixed_block_free_list_allocator_tb.sv
// ============================================================================
// fixed_block_free_list_allocator_tb
// Self-checking bench for the block pool allocator. Requests go in on the
// input stream with random gaps. A free-list predictor inside the bench
// works out the reply to each accepted request, and every output
// transaction is checked in order against it. Directed tests cover reset,
// exhaustion, range errors, double free, a zero count and the widest
// offsets. Random traffic then runs over several pool settings, with
// output back-pressure.
// ============================================================================
module fixed_block_free_list_allocator_tb;
  import fbfl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLOCKS = 256;
  localparam logic [CNT_W-1:0] LIST_END = 9'd256;
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;   // unused op code, no operation

  // one expected reply, laid out as on out_tdata
  typedef struct packed {
    logic [OFS_W-1:0] ofs;
    logic [IDX_W-1:0] idx;
    status_t          st;
  } pool_reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr = '0;
  logic [CFG_D_W-1:0]  cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata = '0;   // op[1:0], block_index[9:2], zero pad
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_TD_W-1:0] out_tdata;       // status[1:0], granted_index[9:2],
                                        // byte_offset[33:10], zero pad

  // predictor state: pool settings and the free list
  logic [CNT_W-1:0]  pool_count = COUNT_RST;
  logic [SIZE_W-1:0] pool_bytes = BYTES_RST;
  logic [CNT_W-1:0]  link_mem [MAX_BLOCKS];
  logic [CNT_W-1:0]  head = LIST_END;

  pool_reply_t       replies_due[$];
  logic [IDX_W-1:0]  held_blocks[$];    // blocks granted to us, not yet returned
  int                n_errors = 0;
  int                hold_cycles = 0;
  bit                no_gaps = 1'b0;

  fixed_block_free_list_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_failure(string what);
    if (n_errors < 10) $display("ERROR @%0t: %s", $time, what);
    n_errors++;
  endfunction

  // apply one request to the free list and return the reply it must give
  function automatic pool_reply_t apply_pool_request(logic [OP_W-1:0] op,
                                                     logic [IDX_W-1:0] blk);
    pool_reply_t r;
    logic [CNT_W-1:0] nxt;
    int eff_cnt;
    int eff_size;
    int i;
    r = '{ofs: '0, idx: '0, st: ST_OK};
    eff_cnt = (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(pool_count);
    eff_size = (pool_bytes < MIN_SIZE) ? MIN_SIZE : int'(pool_bytes);
    case (op)
      OP_INIT: begin
        for (i = 0; i < eff_cnt; i++)
          link_mem[i] = (i + 1 < eff_cnt) ? CNT_W'(i + 1) : LIST_END;
        head = (eff_cnt == 0) ? LIST_END : '0;
      end
      OP_ALLOC: begin
        if (head >= LIST_END) begin
          r.st = ST_EMPTY;
        end else begin
          r.idx = head[IDX_W-1:0];
          r.ofs = OFS_W'(int'(head) * eff_size);
          nxt = link_mem[head[IDX_W-1:0]];
          head = (nxt >= LIST_END) ? LIST_END : nxt;
        end
      end
      OP_FREE: begin
        if (int'(blk) >= eff_cnt) begin
          r.st = ST_RANGE;
        end else begin
          link_mem[blk] = head;
          head = {1'b0, blk};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // idle length before a transaction: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // send one request; valid stays up after the transaction so that a
  // back-to-back request needs no second assignment in the same step
  task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] blk);
    int gap;
    pool_reply_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TD_W - OP_W - IDX_W){1'b0}}, blk, op};
    do @(posedge clk); while (!in_tready);
    r = apply_pool_request(op, blk);
    replies_due.push_back(r);
    if (op == OP_INIT) held_blocks.delete();
    else if (op == OP_ALLOC && r.st == ST_OK) held_blocks.push_back(r.idx);
  endtask

  // stop sending and wait until every reply has come back
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [CFG_D_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= which;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (which == CFG_BLOCK_COUNT) pool_count = val[CNT_W-1:0];
    else pool_bytes = val;
  endtask

  // random mix: mostly allocate and return of held blocks, plus noise
  task automatic run_traffic(int n_items);
    int k;
    int roll;
    int pick;
    logic [IDX_W-1:0] blk;
    for (k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      blk = IDX_W'($urandom_range(0, 255));
      if (roll < 40) begin
        if (held_blocks.size() > 0) begin
          pick = $urandom_range(0, held_blocks.size() - 1);
          blk = held_blocks[pick];
          held_blocks.delete(pick);
          send_request(OP_FREE, blk);
        end else begin
          send_request(OP_ALLOC, blk);
        end
      end else if (roll < 46) begin
        send_request(OP_FREE, blk);      // may be out of range or a double free
      end else if (roll < 50) begin
        send_request(OP_NOP, blk);
      end else if (roll < 52) begin
        send_request(OP_INIT, blk);
      end else begin
        send_request(OP_ALLOC, blk);
      end
    end
  endtask

  // reset settings, list empty until the first init
  task automatic test_reset_state();
    send_request(OP_ALLOC, 8'h00);
    send_request(OP_NOP, 8'hFF);
    send_request(OP_FREE, 8'hFF);
    send_request(OP_ALLOC, 8'h00);
    send_request(OP_ALLOC, 8'hFF);
    send_request(OP_INIT, 8'hAA);
    send_request(OP_ALLOC, 8'h55);
    drain_replies();
  endtask

  // tiny pool: exhaustion, range errors, double free, size below minimum
  task automatic test_small_pool();
    write_reg(CFG_BLOCK_COUNT, 16'd4);
    write_reg(CFG_BLOCK_BYTES, 16'd3);
    send_request(OP_INIT, 8'h00);
    repeat (5) send_request(OP_ALLOC, 8'h00);
    send_request(OP_FREE, 8'd4);
    send_request(OP_FREE, 8'd3);
    send_request(OP_FREE, 8'd3);
    send_request(OP_ALLOC, 8'h00);
    send_request(OP_ALLOC, 8'h00);
    drain_replies();
  endtask

  // zero count: init leaves the list empty, every free is out of range
  task automatic test_zero_count();
    write_reg(CFG_BLOCK_COUNT, 16'd0);
    send_request(OP_INIT, 8'h00);
    send_request(OP_ALLOC, 8'h00);
    send_request(OP_FREE, 8'h00);
    drain_replies();
  endtask

  // saturated count and largest size give the widest offset
  task automatic test_wide_values();
    write_reg(CFG_BLOCK_COUNT, 16'd511);
    write_reg(CFG_BLOCK_BYTES, 16'hFFFF);
    send_request(OP_INIT, 8'h00);
    send_request(OP_FREE, 8'hFF);
    send_request(OP_ALLOC, 8'h00);
    drain_replies();
  endtask

  // long output hold while requests keep coming, then a full pause
  task automatic test_backpressure();
    write_reg(CFG_BLOCK_COUNT, 16'd16);
    write_reg(CFG_BLOCK_BYTES, 16'd8);
    no_gaps = 1'b1;
    send_request(OP_INIT, 8'h00);
    hold_cycles = 300;
    run_traffic(40);
    no_gaps = 1'b0;
    drain_replies();
  endtask

  task automatic test_random_traffic();
    logic [CFG_D_W-1:0] cnt;
    logic [CFG_D_W-1:0] sz;
    int ph;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cnt = 16'd1; sz = 16'd0; end
        1: begin cnt = 16'd2; sz = 16'hFFFF; end
        2: begin
          cnt = CFG_D_W'($urandom_range(3, 16));
          sz  = CFG_D_W'($urandom_range(4, 64));
        end
        3: begin
          cnt = CFG_D_W'($urandom_range(17, 64));
          sz  = CFG_D_W'($urandom_range(0, 65535));
        end
        4: begin
          cnt = CFG_D_W'(MAX_BLOCKS);
          sz  = CFG_D_W'(MIN_SIZE);
        end
        default: begin
          cnt = CFG_D_W'($urandom_range(257, 511));
          sz  = CFG_D_W'($urandom_range(0, 3));
        end
      endcase
      write_reg(CFG_BLOCK_COUNT, cnt);
      write_reg(CFG_BLOCK_BYTES, sz);
      no_gaps = (ph == 3);          // one stretch with no idling on either side
      send_request(OP_INIT, IDX_W'($urandom_range(0, 255)));
      run_traffic((ph < 2) ? 160 : 300);
      drain_replies();
    end
    no_gaps = 1'b0;
  endtask

  // output ready: random stalls, plus the long hold when one is requested
  initial begin : out_ready_gen
    int n;
    forever begin
      @(posedge clk);
      n = 0;
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else if (!no_gaps && $urandom_range(0, 99) < 20) begin
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(15, 50);
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // compare each reply transaction with the oldest expectation
  always @(posedge clk) begin : reply_check
    pool_reply_t want;
    pool_reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = pool_reply_t'(out_tdata[OFS_W+IDX_W+STAT_W-1:0]);
      if (replies_due.size() == 0) begin
        note_failure($sformatf("unexpected reply status %0d index %0d offset %0d",
                               got.st, got.idx, got.ofs));
      end else begin
        want = replies_due.pop_front();
        if (got.st != want.st || got.idx != want.idx || got.ofs != want.ofs)
          note_failure($sformatf(
            "reply mismatch: status %0d/%0d index %0d/%0d offset %0d/%0d (exp/got)",
            want.st, got.st, want.idx, got.idx, want.ofs, got.ofs));
      end
    end
  end

  initial begin
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    foreach (link_mem[i]) link_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_small_pool();
    test_zero_count();
    test_wide_values();
    test_backpressure();
    test_random_traffic();
    drain_replies();
    repeat (20) @(posedge clk);
    if (n_errors == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
